[hdl/itok_pkg.sv]
`timescale 1ns / 1ps

package itok_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int REPORT_BITS    = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [REPORT_BITS-1:0] REPORT_MAX = '1;

    localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_BITS-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_BITS-1:0] CH_LBR   = 8'h5B;
    localparam logic [BYTE_BITS-1:0] CH_BSL   = 8'h5C;
    localparam logic [BYTE_BITS-1:0] CH_RBR   = 8'h5D;
    localparam logic [BYTE_BITS-1:0] CH_N     = 8'h6E;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SECTION_SEP = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KEYVAL_SEP  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COMMENT_A   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COMMENT_B   = 2'd3;

    localparam logic [BYTE_BITS-1:0] RST_SECTION_SEP = 8'd29;
    localparam logic [BYTE_BITS-1:0] RST_KEYVAL_SEP  = 8'd30;
    localparam logic [BYTE_BITS-1:0] RST_COMMENT_A   = 8'd35;
    localparam logic [BYTE_BITS-1:0] RST_COMMENT_B   = 8'd59;

    typedef enum logic [2:0] {
        PH_START,
        PH_BLANK,
        PH_CHECK,
        PH_COMMENT,
        PH_BODY
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   escape_pending;
        logic   in_quote;
        logic   line_has_equal;
        logic   continued_line;
        logic   on_section_line;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:           PH_START,
        escape_pending:  1'b0,
        in_quote:        1'b0,
        line_has_equal:  1'b0,
        continued_line:  1'b0,
        on_section_line: 1'b0
    };

    typedef struct packed {
        logic [BYTE_BITS-1:0] section_sep_char;
        logic [BYTE_BITS-1:0] keyval_sep_char;
        logic [BYTE_BITS-1:0] comment_char_a;
        logic [BYTE_BITS-1:0] comment_char_b;
    } cfg_regs_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] text_byte;
        logic                 is_final;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0]   token_byte;
        logic                   byte_valid;
        logic                   stream_done;
        logic [REPORT_BITS-1:0] keys_found;
        logic [REPORT_BITS-1:0] sections_found;
    } out_item_t;

endpackage

[hdl/itok_parser.sv]
`timescale 1ns / 1ps

module itok_parser #(
    parameter int COUNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  itok_pkg::in_item_t  item,
    input  itok_pkg::cfg_regs_t cfg,
    output logic              res_valid,
    output itok_pkg::out_item_t res
);
    import itok_pkg::*;

    localparam int WIDE_BITS = COUNT_BITS + REPORT_BITS;

    parse_state_t            state_reg, state_next;
    logic [COUNT_BITS-1:0]   key_tally_reg, key_tally_next;
    logic [COUNT_BITS-1:0]   section_tally_reg, section_tally_next;

    logic [BYTE_BITS-1:0]    b;
    logic [BYTE_BITS-1:0]    ob;
    logic                    emit;
    logic                    skip;
    logic                    plain;
    logic [WIDE_BITS-1:0]    key_wide;
    logic [WIDE_BITS-1:0]    section_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= PARSE_RESET;
            key_tally_reg     <= '0;
            section_tally_reg <= '0;
        end
        else if (fire)
        begin
            state_reg         <= state_next;
            key_tally_reg     <= key_tally_next;
            section_tally_reg <= section_tally_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        key_tally_next     = key_tally_reg;
        section_tally_next = section_tally_reg;
        emit               = 1'b0;
        ob                 = '0;
        skip               = 1'b0;
        plain              = 1'b0;
        b                  = item.text_byte;

        if (b != cfg.section_sep_char && b != cfg.keyval_sep_char)
        begin
            if (b == CH_CR)
            begin
                b = CH_LF;
            end
            if (state_next.phase == PH_START)
            begin
                if (!state_next.continued_line)
                begin
                    state_next.line_has_equal = 1'b0;
                end
                state_next.phase = PH_BLANK;
            end
            if (state_next.phase == PH_BLANK)
            begin
                if (b inside {CH_LF, CH_SP, CH_TAB})
                begin
                    if (b == CH_LF)
                    begin
                        state_next.line_has_equal = 1'b0;
                    end
                    skip = 1'b1;
                end
                else
                begin
                    state_next.phase = PH_CHECK;
                end
            end
            if (!skip && state_next.phase == PH_COMMENT)
            begin
                if (b == CH_LF)
                begin
                    state_next.phase = PH_CHECK;
                end
                skip = 1'b1;
            end
            if (!skip && state_next.phase == PH_CHECK
                && (b == cfg.comment_char_a || b == cfg.comment_char_b))
            begin
                state_next.line_has_equal = 1'b0;
                state_next.phase = (b == CH_LF) ? PH_CHECK : PH_COMMENT;
                skip = 1'b1;
            end

            // line body
            if (!skip)
            begin
                state_next.phase = (b == CH_LF) ? PH_START : PH_BODY;
                if (state_next.escape_pending)
                begin
                    state_next.escape_pending = 1'b0;
                    if (b == CH_N)
                    begin
                        emit = 1'b1;
                        ob   = CH_LF;
                    end
                    else if (b == CH_BSL)
                    begin
                        emit = 1'b1;
                        ob   = CH_BSL;
                    end
                    else if (b == CH_SP || b == CH_LF)
                    begin
                        state_next.continued_line = 1'b1;
                    end
                    else
                    begin
                        plain = 1'b1;
                    end
                end
                else
                begin
                    case (b)
                        CH_SP, CH_TAB:
                        begin
                            plain = state_next.in_quote;
                        end
                        CH_QUOTE:
                        begin
                            state_next.in_quote = !state_next.in_quote;
                        end
                        CH_EQ:
                        begin
                            state_next.in_quote       = 1'b0;
                            state_next.line_has_equal = 1'b1;
                            if (key_tally_reg != '1)
                            begin
                                key_tally_next = key_tally_reg + COUNT_BITS'(1);
                            end
                            emit = 1'b1;
                            ob   = cfg.keyval_sep_char;
                        end
                        CH_LF:
                        begin
                            state_next.continued_line = 1'b0;
                            if (!state_next.on_section_line
                                && (state_next.line_has_equal || state_next.in_quote))
                            begin
                                state_next.in_quote = 1'b0;
                                emit = 1'b1;
                                ob   = cfg.keyval_sep_char;
                            end
                            state_next.on_section_line = 1'b0;
                        end
                        CH_LBR:
                        begin
                            state_next.on_section_line = 1'b1;
                            if (section_tally_reg != '1)
                            begin
                                section_tally_next = section_tally_reg + COUNT_BITS'(1);
                            end
                            state_next.in_quote = 1'b0;
                            emit = 1'b1;
                            ob   = cfg.section_sep_char;
                        end
                        CH_RBR:
                        begin
                            state_next.in_quote = 1'b0;
                            emit = 1'b1;
                            ob   = cfg.section_sep_char;
                        end
                        default:
                        begin
                            plain = 1'b1;
                        end
                    endcase
                end
                if (plain)
                begin
                    if (b == CH_BSL)
                    begin
                        state_next.escape_pending = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                        ob   = b;
                    end
                end
            end
        end

        key_wide     = WIDE_BITS'(key_tally_next);
        section_wide = WIDE_BITS'(section_tally_next);

        res_valid          = emit || item.is_final;
        res.token_byte     = emit ? ob : '0;
        res.byte_valid     = emit;
        res.stream_done    = item.is_final;
        res.keys_found     = '0;
        res.sections_found = '0;
        if (item.is_final)
        begin
            res.keys_found     = (key_wide > WIDE_BITS'(REPORT_MAX))
                                 ? REPORT_MAX : key_wide[REPORT_BITS-1:0];
            res.sections_found = (section_wide > WIDE_BITS'(REPORT_MAX))
                                 ? REPORT_MAX : section_wide[REPORT_BITS-1:0];
            // buffer ends: parse state and tallies go back to reset
            state_next         = PARSE_RESET;
            key_tally_next     = '0;
            section_tally_next = '0;
        end
    end

endmodule

[hdl/itok_out_stage.sv]
`timescale 1ns / 1ps

module itok_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  itok_pkg::out_item_t load_item,
    input  logic                out_stall,
    output logic                out_free,
    output logic                out_valid,
    output itok_pkg::out_item_t out_item
);
    import itok_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

endmodule

[hdl/ini_text_tokenizer_core.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        in         in_valid / in_stall       in_item (text_byte, is_final)
// out       out        out_valid / out_stall     out_item (token, flags, counts)
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; an accepted item is loaded into the
// input register, and its result goes into the result register when the parser fires
// the parse state updates once per item through combinational flag logic
// rst_n clears parse state, tallies, valids and loads register defaults
// out_stall holds the result register and then the input register; cfg is always ready

module ini_text_tokenizer_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  itok_pkg::in_item_t                        in_item,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output itok_pkg::out_item_t                       out_item,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [itok_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [itok_pkg::BYTE_BITS-1:0]            cfg_data
);
    import itok_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    cfg_regs_t cfg_reg;
    logic      accept;
    logic      fire;
    logic      out_free;
    logic      res_valid;
    out_item_t res;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !fire;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.section_sep_char <= RST_SECTION_SEP;
            cfg_reg.keyval_sep_char  <= RST_KEYVAL_SEP;
            cfg_reg.comment_char_a   <= RST_COMMENT_A;
            cfg_reg.comment_char_b   <= RST_COMMENT_B;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SECTION_SEP: cfg_reg.section_sep_char <= cfg_data;
                CFG_KEYVAL_SEP:  cfg_reg.keyval_sep_char  <= cfg_data;
                CFG_COMMENT_A:   cfg_reg.comment_char_a   <= cfg_data;
                CFG_COMMENT_B:   cfg_reg.comment_char_b   <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    itok_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    itok_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .load_item (res),
        .out_stall (out_stall),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

[hdl/itok_checker.sv]
`timescale 1ns / 1ps

module itok_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input itok_pkg::out_item_t                 out_item
);
    import itok_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // a result without a byte is only the end of a buffer
    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.byte_valid |-> out_item.stream_done)
        else $error("empty result not marked final");

    // counts only appear with the final item
    a_counts_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.stream_done
        |-> out_item.keys_found == '0 && out_item.sections_found == '0)
        else $error("counts outside final result");

    // token byte is zero when not carried
    a_token_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.byte_valid |-> out_item.token_byte == '0)
        else $error("token byte set without byte_valid");

endmodule

bind ini_text_tokenizer_core itok_checker u_itok_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

[sim/ini_text_tokenizer_core_checker.sv]
`timescale 1ns / 1ps

module ini_text_tokenizer_core_checker #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  itok_pkg::in_item_t                  in_item,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  itok_pkg::out_item_t                 out_item,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [itok_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [itok_pkg::BYTE_BITS-1:0]      cfg_data,
    output int                                  mismatches,
    output int                                  tokens_pending,
    output int                                  tokens_checked
);
    import itok_pkg::*;

    localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    cfg_regs_t       regs;
    parse_state_t    ps;
    longint unsigned key_cnt;
    longint unsigned sect_cnt;
    out_item_t       expected_tokens [$];

    function automatic longint unsigned bumped(input longint unsigned t);
        return (t < TALLY_MAX) ? t + 64'd1 : t;
    endfunction

    function automatic logic [REPORT_BITS-1:0] reported(input longint unsigned t);
        return (t > 64'(REPORT_MAX)) ? REPORT_MAX : t[REPORT_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (mismatches < 40)
        begin
            $display("%0t token mismatch on %s: expected %0h, got %0h", $realtime, what,
                     want, got);
        end
        mismatches++;
    endtask

    function automatic void predict_token(input in_item_t it);
        logic [BYTE_BITS-1:0] b;
        logic [BYTE_BITS-1:0] ob;
        logic                 emit;
        logic                 skipped;
        logic                 taken;
        out_item_t            token;
        b = it.text_byte;
        ob = '0;
        emit = 1'b0;
        skipped = 1'b0;
        taken = 1'b0;
        if (b == regs.section_sep_char || b == regs.keyval_sep_char)
            skipped = 1'b1;
        else if (b == CH_CR)
            b = CH_LF;
        if (!skipped && ps.phase == PH_START)
        begin
            if (!ps.continued_line)
                ps.line_has_equal = 1'b0;
            ps.phase = PH_BLANK;
        end
        if (!skipped && ps.phase == PH_BLANK)
        begin
            if (b == CH_LF || b == CH_SP || b == CH_TAB)
            begin
                if (b == CH_LF)
                    ps.line_has_equal = 1'b0;
                skipped = 1'b1;
            end
            else
                ps.phase = PH_CHECK;
        end
        if (!skipped && ps.phase == PH_COMMENT)
        begin
            if (b == CH_LF)
                ps.phase = PH_CHECK;
            skipped = 1'b1;
        end
        if (!skipped && ps.phase == PH_CHECK &&
            (b == regs.comment_char_a || b == regs.comment_char_b))
        begin
            ps.line_has_equal = 1'b0;
            ps.phase = (b == CH_LF) ? PH_CHECK : PH_COMMENT;
            skipped = 1'b1;
        end
        if (!skipped)
        begin
            ps.phase = (b == CH_LF) ? PH_START : PH_BODY;
            if (ps.escape_pending)
            begin
                ps.escape_pending = 1'b0;
                taken = 1'b1;
                if (b == CH_N)
                begin
                    emit = 1'b1;
                    ob = CH_LF;
                end
                else if (b == CH_BSL)
                begin
                    emit = 1'b1;
                    ob = CH_BSL;
                end
                else if (b == CH_SP || b == CH_LF)
                    ps.continued_line = 1'b1;
                else
                    taken = 1'b0;
            end
            else
            begin
                case (b)
                    CH_SP, CH_TAB:
                    begin
                        if (!ps.in_quote)
                            taken = 1'b1;
                    end
                    CH_QUOTE:
                    begin
                        ps.in_quote = !ps.in_quote;
                        taken = 1'b1;
                    end
                    CH_EQ:
                    begin
                        ps.in_quote = 1'b0;
                        ps.line_has_equal = 1'b1;
                        key_cnt = bumped(key_cnt);
                        emit = 1'b1;
                        ob = regs.keyval_sep_char;
                        taken = 1'b1;
                    end
                    CH_LF:
                    begin
                        ps.continued_line = 1'b0;
                        if (!ps.on_section_line && (ps.line_has_equal || ps.in_quote))
                        begin
                            ps.in_quote = 1'b0;
                            emit = 1'b1;
                            ob = regs.keyval_sep_char;
                        end
                        ps.on_section_line = 1'b0;
                        taken = 1'b1;
                    end
                    CH_LBR:
                    begin
                        ps.on_section_line = 1'b1;
                        sect_cnt = bumped(sect_cnt);
                        ps.in_quote = 1'b0;
                        emit = 1'b1;
                        ob = regs.section_sep_char;
                        taken = 1'b1;
                    end
                    CH_RBR:
                    begin
                        ps.in_quote = 1'b0;
                        emit = 1'b1;
                        ob = regs.section_sep_char;
                        taken = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (!taken)
            begin
                if (b == CH_BSL)
                    ps.escape_pending = 1'b1;
                else
                begin
                    emit = 1'b1;
                    ob = b;
                end
            end
        end
        if (emit || it.is_final)
        begin
            token.token_byte = emit ? ob : '0;
            token.byte_valid = emit;
            token.stream_done = it.is_final;
            token.keys_found = it.is_final ? reported(key_cnt) : '0;
            token.sections_found = it.is_final ? reported(sect_cnt) : '0;
            expected_tokens.push_back(token);
        end
        if (it.is_final)
        begin
            ps = PARSE_RESET;
            key_cnt = 0;
            sect_cnt = 0;
        end
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            regs = '{RST_SECTION_SEP, RST_KEYVAL_SEP, RST_COMMENT_A, RST_COMMENT_B};
            ps = PARSE_RESET;
            key_cnt = 0;
            sect_cnt = 0;
            expected_tokens.delete();
            mismatches = 0;
            tokens_checked = 0;
            tokens_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SECTION_SEP: regs.section_sep_char = cfg_data;
                    CFG_KEYVAL_SEP:  regs.keyval_sep_char = cfg_data;
                    CFG_COMMENT_A:   regs.comment_char_a = cfg_data;
                    CFG_COMMENT_B:   regs.comment_char_b = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                    report_mismatch("item with nothing expected", 0, out_item);
                else
                begin
                    want = expected_tokens.pop_front();
                    tokens_checked++;
                    if (out_item.token_byte !== want.token_byte)
                        report_mismatch("token_byte", want.token_byte, out_item.token_byte);
                    if (out_item.byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", want.byte_valid, out_item.byte_valid);
                    if (out_item.stream_done !== want.stream_done)
                        report_mismatch("stream_done", want.stream_done, out_item.stream_done);
                    if (out_item.keys_found !== want.keys_found)
                        report_mismatch("keys_found", want.keys_found, out_item.keys_found);
                    if (out_item.sections_found !== want.sections_found)
                        report_mismatch("sections_found", want.sections_found,
                                        out_item.sections_found);
                end
            end
            if (in_valid && !in_stall)
                predict_token(in_item);
            tokens_pending <= expected_tokens.size();
        end
    end

endmodule

[sim/ini_text_tokenizer_core_tb.sv]
`timescale 1ns / 1ps

module ini_text_tokenizer_core_tb;
    import itok_pkg::*;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    in_item_t                  in_item = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_item_t                 out_item;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_SECTION_SEP;
    logic [BYTE_BITS-1:0]      cfg_data = '0;

    int mismatches;
    int tokens_pending;
    int tokens_checked;
    int bytes_sent = 0;
    int buffers_sent = 0;
    int idle_cycles = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    bit rx_hold_req = 1'b0;

    logic [BYTE_BITS-1:0] sep_now = RST_SECTION_SEP;
    logic [BYTE_BITS-1:0] kv_now = RST_KEYVAL_SEP;
    logic [BYTE_BITS-1:0] cmt_a_now = RST_COMMENT_A;
    logic [BYTE_BITS-1:0] cmt_b_now = RST_COMMENT_B;
    logic [BYTE_BITS-1:0] text_q [$];

    always #10 clk = ~clk;

    ini_text_tokenizer_core #(
        .COUNT_BITS(16)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ini_text_tokenizer_core_checker #(
        .COUNT_BITS(16)
    ) token_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .tokens_pending (tokens_pending),
        .tokens_checked (tokens_checked)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles, %0d tokens outstanding",
                     idle_cycles, tokens_pending);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else if (rx_stalls_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (idle_len()) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic fin);
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
        in_item <= '{text_byte: b, is_final: fin};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic fin_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_at_end && (i == s.len() - 1));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (tokens_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_regs(input logic [BYTE_BITS-1:0] sep, input logic [BYTE_BITS-1:0] kv,
                             input logic [BYTE_BITS-1:0] ca, input logic [BYTE_BITS-1:0] cb);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SECTION_SEP;
        cfg_data <= sep;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_KEYVAL_SEP;
        cfg_data <= kv;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_COMMENT_A;
        cfg_data <= ca;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_COMMENT_B;
        cfg_data <= cb;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sep_now = sep;
        kv_now = kv;
        cmt_a_now = ca;
        cmt_b_now = cb;
        @(posedge clk);
    endtask

    function automatic logic [BYTE_BITS-1:0] value_char();
        int r;
        r = $urandom_range(0, 23);
        case (r)
            0:       return CH_QUOTE;
            1:       return CH_SP;
            2:       return CH_TAB;
            3:       return CH_EQ;
            4:       return CH_LBR;
            5:       return CH_RBR;
            6:       return sep_now;
            7:       return kv_now;
            8:       return cmt_a_now;
            9:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic void add_name();
        repeat ($urandom_range(1, 6))
            text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    endfunction

    function automatic void add_value();
        repeat ($urandom_range(0, 8))
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                text_q.push_back(CH_BSL);
                case ($urandom_range(0, 4))
                    0:       text_q.push_back(CH_N);
                    1:       text_q.push_back(CH_BSL);
                    2:       text_q.push_back(CH_SP);
                    3:       text_q.push_back(CH_LF);
                    default: text_q.push_back(value_char());
                endcase
            end
            else
                text_q.push_back(value_char());
        end
    endfunction

    function automatic void add_line();
        int kind;
        kind = $urandom_range(0, 11);
        repeat ($urandom_range(0, 2))
            text_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        case (kind)
            0, 1, 2, 3, 4:
            begin
                add_name();
                repeat ($urandom_range(0, 1)) text_q.push_back(CH_SP);
                text_q.push_back(CH_EQ);
                add_value();
            end
            5, 6:
            begin
                text_q.push_back(CH_LBR);
                add_name();
                text_q.push_back(CH_RBR);
            end
            7:
            begin
                text_q.push_back($urandom_range(0, 1) ? cmt_a_now : cmt_b_now);
                add_value();
            end
            8:
            begin
            end
            9:
            begin
                add_name();
                add_value();
            end
            10:
            begin
                // quote left open up to the line end
                add_name();
                text_q.push_back(CH_EQ);
                text_q.push_back(CH_QUOTE);
                add_value();
            end
            default:
            begin
                repeat ($urandom_range(1, 12))
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        case ($urandom_range(0, 3))
            0:       text_q.push_back(CH_CR);
            1:
            begin
                text_q.push_back(CH_CR);
                text_q.push_back(CH_LF);
            end
            default: text_q.push_back(CH_LF);
        endcase
    endfunction

    task automatic send_buffer();
        int cut;
        text_q.delete();
        repeat ($urandom_range(1, 8)) add_line();
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, text_q.size() - 1)
                                          : text_q.size() - 1;
        for (int i = 0; i <= cut; i++)
            send_byte(text_q[i], i == cut);
        buffers_sent++;
    endtask

    task automatic run_phase(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_buffer();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text(" \t#\r;\n[s]\nk=\" b\"\\n\\\\\\ \n", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(RST_SECTION_SEP, 1'b0);
        send_byte(RST_KEYVAL_SEP, 1'b1);
        wait_idle();

        run_phase(200);
        rx_hold_req = 1'b1;
        run_phase(250);
        wait_idle();

        load_regs(8'h00, 8'hFF, CH_LF, CH_LBR);
        run_phase(400);
        wait_idle();

        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        load_regs(8'hFF, 8'h00, 8'h00, 8'h21);
        run_phase(350);
        wait_idle();

        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_phase(450);
        wait_idle();

        $display("tokenizer run: %0d text bytes in %0d random buffers, %0d tokens compared",
                 bytes_sent, buffers_sent, tokens_checked);
        $display("four register settings, a long output hold-off and a gapless stretch");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
